// ----- design/sia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg
// Operation codes and constants shared by the saturating ALU.
// ----------------------------------------------------------------------------
package sia_pkg;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_NEG  = 4'd2,
    OP_ABS  = 4'd3,
    OP_MUL  = 4'd4,
    OP_SHL  = 4'd5,
    OP_SHR  = 4'd6,
    OP_CMP  = 4'd7,
    OP_BITS = 4'd8
  } op_t;

  localparam logic [63:0] PINF = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MINF = 64'h8000_0000_0000_0000;
  localparam logic [63:0] INF_BITS = 64'd65;

endpackage
`default_nettype wire

// ----- design/saturating_infinity_alu_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// saturating_infinity_alu_top
// 64-bit signed ALU whose extreme values stand for plus and minus infinity.
// ----------------------------------------------------------------------------
// One item enters per cycle while the output does not stall the pipe, and its
// result leaves through four register stages: operand decode and magnitudes,
// the three 32x32 partial products of the multiplier with the check for two
// nonzero high halves, their sum and the saturation checks, and the output
// register. The multiplier's partial products set that depth. A stage holds
// its item while the stage after it is full and cannot move on.
module saturating_infinity_alu_top (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [135:0] in_tdata,   // operation[3:0], operand_a[67:4], operand_b[131:68]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata    // result[63:0], less, equal, greater, shift_error
);

  // Stage 1: decode, everything except multiplication finished here.
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        adv1, adv2, adv3, adv4;

  assign adv4 = !v4_r || out_tready;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;
  assign in_tready = adv1;

  logic [3:0]  op;
  logic [63:0] a, b;
  assign op = in_tdata[3:0];
  assign a  = in_tdata[67:4];
  assign b  = in_tdata[131:68];

  function automatic logic [63:0] sat_of(input logic [63:0] x);
    return x[63] ? sia_pkg::MINF : sia_pkg::PINF;
  endfunction

  logic [63:0] res_nxt, sum, dif, abs_a, abs_b, shl_v, shr_v, lz_v;
  logic [6:0]  len;
  logic        lt_nxt, eq_nxt, gt_nxt, err_nxt, a_inf, b_inf;
  logic        mul_nxt, msign_nxt, mforce_nxt;
  logic [127:0] shl_w;

  assign a_inf = (a == sia_pkg::PINF) || (a == sia_pkg::MINF);
  assign b_inf = (b == sia_pkg::PINF) || (b == sia_pkg::MINF);
  assign sum   = a + b;
  assign dif   = a - b;
  assign abs_a = (a == sia_pkg::MINF) ? sia_pkg::PINF : (a[63] ? (64'd0 - a) : a);
  assign abs_b = (b == sia_pkg::MINF) ? sia_pkg::PINF : (b[63] ? (64'd0 - b) : b);
  assign shl_w = {{64{a[63]}}, a} << b[5:0];
  assign lz_v  = a[63] ? ~a : a;

  always_comb begin
    shl_v = shl_w[63:0];
    if (b[62:6] != 57'd0) begin
      shl_v = (a == 64'd0) ? 64'd0 : sat_of(a);
    end else if (shl_w[127:63] != {65{a[63]}}) begin
      shl_v = sat_of(a);
    end
    if (a_inf) begin
      shr_v = a;
    end else if (b[62:6] != 57'd0) begin
      shr_v = {64{a[63]}};
    end else begin
      shr_v = $signed(a) >>> b[5:0];
    end
    // Zero and negative values count one extra bit for the sign.
    len = {6'd0, (a == 64'd0) || a[63]};
    for (int i = 0; i < 63; i++) begin
      if (lz_v[i]) len = 7'(i + 1) + {6'd0, a[63]};
    end
  end

  always_comb begin
    res_nxt = 64'd0; lt_nxt = 1'b0; eq_nxt = 1'b0; gt_nxt = 1'b0; err_nxt = 1'b0;
    mul_nxt = 1'b0; msign_nxt = a[63] ^ b[63]; mforce_nxt = 1'b0;
    unique case (op)
      sia_pkg::OP_ADD: begin
        if (a_inf && b_inf && a != b) res_nxt = 64'd0;
        else if (a_inf) res_nxt = a;
        else if (b_inf) res_nxt = b;
        else if (a[63] == b[63] && sum[63] != a[63]) res_nxt = sat_of(a);
        else res_nxt = sum;
      end
      sia_pkg::OP_SUB: begin
        if (a_inf) res_nxt = (a == b) ? 64'd0 : a;
        else if (b == sia_pkg::MINF) res_nxt = sia_pkg::PINF;
        else if (b == sia_pkg::PINF) res_nxt = sia_pkg::MINF;
        else if (a[63] != b[63] && dif[63] != a[63]) res_nxt = sat_of(a);
        else res_nxt = dif;
      end
      sia_pkg::OP_NEG: res_nxt = (a == sia_pkg::MINF) ? sia_pkg::PINF : 64'd0 - a;
      sia_pkg::OP_ABS: res_nxt = abs_a;
      sia_pkg::OP_MUL: begin
        mul_nxt = 1'b1;
        // Minus infinity times a positive value is minus infinity outright.
        mforce_nxt = (!a[63] && a != 64'd0 && b == sia_pkg::MINF) ||
                     (!b[63] && b != 64'd0 && a == sia_pkg::MINF);
      end
      sia_pkg::OP_SHL: begin
        if (b[63]) err_nxt = 1'b1; else res_nxt = shl_v;
      end
      sia_pkg::OP_SHR: begin
        if (b[63]) err_nxt = 1'b1; else res_nxt = shr_v;
      end
      sia_pkg::OP_CMP: begin
        lt_nxt = $signed(a) < $signed(b);
        eq_nxt = a == b;
        gt_nxt = $signed(a) > $signed(b);
      end
      sia_pkg::OP_BITS: res_nxt = a_inf ? sia_pkg::INF_BITS : {57'd0, len};
      default: res_nxt = 64'd0;
    endcase
  end

  logic [63:0] res1_r, ma_r, mb_r;
  logic [3:0]  fl1_r;
  logic        mul1_r, msign1_r, mforce1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv1) begin
      v1_r <= in_tvalid;
    end
    if (adv1) begin
      res1_r <= res_nxt; fl1_r <= {err_nxt, gt_nxt, eq_nxt, lt_nxt};
      ma_r <= abs_a; mb_r <= abs_b;
      mul1_r <= mul_nxt; msign1_r <= msign_nxt; mforce1_r <= mforce_nxt;
    end
  end

  // Stage 2: partial products of the magnitudes.
  logic [63:0] p11_r, p12_r, p21_r, res2_r;
  logic        hh_r, mul2_r, msign2_r, mforce2_r;
  logic [3:0]  fl2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv2) begin
      v2_r <= v1_r;
    end
    if (adv2) begin
      p11_r <= ma_r[31:0] * mb_r[31:0];
      p12_r <= ma_r[31:0] * mb_r[63:32];
      p21_r <= ma_r[63:32] * mb_r[31:0];
      hh_r  <= (ma_r[63:32] != 32'd0) && (mb_r[63:32] != 32'd0);
      res2_r <= res1_r; fl2_r <= fl1_r;
      mul2_r <= mul1_r; msign2_r <= msign1_r; mforce2_r <= mforce1_r;
    end
  end

  // Stage 3: sum and saturation.
  logic [64:0] cross_sum;
  logic [65:0] prod;
  logic        msat;
  logic [63:0] mres, res3_nxt;

  assign cross_sum = {1'b0, p12_r} + {1'b0, p21_r};
  assign prod  = {2'b00, p11_r} + {1'b0, cross_sum[31:0], 32'd0};
  assign msat  = hh_r || (cross_sum[64:32] != 33'd0) || (prod[65:63] != 3'd0);

  always_comb begin
    if (mforce2_r) mres = sia_pkg::MINF;
    else if (msat) mres = msign2_r ? sia_pkg::MINF : sia_pkg::PINF;
    else mres = msign2_r ? (64'd0 - prod[63:0]) : prod[63:0];
    res3_nxt = mul2_r ? mres : res2_r;
  end

  logic [63:0] res3_r;
  logic [3:0]  fl3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv3) begin
      v3_r <= v2_r;
    end
    if (adv3) begin
      res3_r <= res3_nxt; fl3_r <= fl2_r;
    end
  end

  // Stage 4: output register.
  logic [63:0] res4_r;
  logic [3:0]  fl4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv4) begin
      v4_r <= v3_r;
    end
    if (adv4) begin
      res4_r <= res3_r; fl4_r <= fl3_r;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'd0, fl4_r, res4_r};

`ifndef SYNTH
  // At most one compare flag is ever set.
  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> $onehot0(fl4_r[2:0])) else $error("compare flags not exclusive");
  // A held output item keeps its data.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && !out_tready |=> v4_r && $stable(res4_r))
    else $error("stalled item changed");
  // A shift error always carries a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && fl4_r[3] |-> res4_r == 64'd0) else $error("shift error with nonzero result");
  // An item in stage one moves on one stage when the pipe advances.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && adv2 |=> v2_r) else $error("item lost between stages");
`endif

endmodule
`default_nettype wire
